[hdl/pwg_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the sine table of the periodic waveform generator.
// Used by every module of the block; depends on nothing else.
package pwg_pkg;

   // Points in one period of the waveform (4 to 256)
   localparam int POINTS = 20;
   localparam int IDX_W  = $clog2(POINTS);

   // Depth of the queue between the tick front end and the sample pipeline
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port geometry
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Fixed-point constants of the sine series
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30     = 64'sd1073741824;

   // Term divisors (n+1)(n+2) of the series, sine terms and cosine terms
   localparam longint SIN_SERIES_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
   localparam longint COS_SERIES_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

   typedef enum logic [1:0] {
      SHAPE_SINE,
      SHAPE_SQUARE,
      SHAPE_TRIANGLE,
      SHAPE_SAWTOOTH
   } shape_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_SHAPE,
      CSR_AMPLITUDE,
      CSR_OFFSET_LEVEL,
      CSR_POINT_PERIOD
   } csr_index_type;

   // Waveform settings seen by the sample pipeline
   typedef struct packed {
      shape_type   shape;
      logic [16:0] amplitude;
      logic [16:0] offset_level;
   } wave_cfg_type;

   // One point handed from the front end to the queue
   typedef struct packed {
      logic       valid;
      logic [7:0] idx;
   } point_push_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef logic signed [17:0] sine_tab_type [POINTS];

   // sin(2*pi*i/POINTS) in Q.16: quadrant split, then an 8-term series in Q.30
   function automatic logic signed [17:0] pwg_sine_q16(int i);
      longint k;
      longint q;
      longint r;
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint v;
      bit     use_cos;
      k       = 4 * longint'(i);
      q       = (k / POINTS) % 4;
      r       = k % POINTS;
      x       = HALF_PI_Q30 * r / POINTS;
      x2      = (x * x) >>> 30;
      use_cos = (q % 2) != 0;
      term    = use_cos ? ONE_Q30 : x;
      sum     = term;
      for (int s = 0; s < 7; s++) begin
         term = (term * x2) >>> 30;
         if (use_cos) begin
            term = term / COS_SERIES_DIV[s];
         end else begin
            term = term / SIN_SERIES_DIV[s];
         end
         if ((s % 2) != 0) begin
            sum = sum + term;
         end else begin
            sum = sum - term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (sum + 8192) >>> 14;
      if (v > 65536) begin
         v = 65536;
      end
      return 18'((q >= 2) ? -v : v);
   endfunction

   function automatic sine_tab_type pwg_sine_table();
      sine_tab_type t;
      for (int j = 0; j < POINTS; j++) begin
         t[j] = pwg_sine_q16(j);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = pwg_sine_table();

endpackage

[hdl/pwg_front.sv]
`timescale 1ns / 1ps
// Tick front end: takes tick/restart items, keeps the tick count and phase index,
// and queues the phase index of every point that is due. Depends on pwg_pkg.
module pwg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_tick,
   input  logic                      req_restart,
   input  logic [31:0]               point_period,
   input  pwg_pkg::queue_status_type q_status,
   output pwg_pkg::point_push_type   q_push
);
   import pwg_pkg::*;

   logic [7:0]  phase_ff, phase_in;
   logic [31:0] tcount_ff, tcount_in;

   logic        accept;
   logic [7:0]  phase_cur;
   logic [31:0] tcount_cur;
   logic [31:0] period_eff;
   logic [32:0] tcount_next;
   logic [8:0]  phase_plus;
   logic        point_due;

   // Hold off new items while the queue has no room
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // Restart clears the state before the tick of the same item is looked at
   always_comb begin
      phase_cur   = req_restart ? 8'd0 : phase_ff;
      tcount_cur  = req_restart ? 32'd0 : tcount_ff;
      period_eff  = (point_period == 32'd0) ? 32'd1 : point_period;
      tcount_next = {1'b0, tcount_cur} + 33'd1;
      phase_plus  = {1'b0, phase_cur} + 9'd1;
      point_due   = req_tick && (tcount_cur == 32'd0);

      phase_in  = phase_ff;
      tcount_in = tcount_ff;
      if (accept) begin
         phase_in  = phase_cur;
         tcount_in = tcount_cur;
         if (point_due) begin
            phase_in = (phase_plus >= 9'(POINTS)) ? 8'd0 : phase_plus[7:0];
         end
         if (req_tick) begin
            tcount_in = (tcount_next >= {1'b0, period_eff}) ? 32'd0 : tcount_next[31:0];
         end
      end
   end

   // Point due: push its phase index
   assign q_push.valid = accept && point_due;
   assign q_push.idx   = phase_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 8'd0;
         tcount_ff <= 32'd0;
      end else begin
         phase_ff  <= phase_in;
         tcount_ff <= tcount_in;
      end
   end

endmodule

[hdl/pwg_queue.sv]
`timescale 1ns / 1ps
// Short point queue between the tick front end and the sample pipeline.
// Depends on pwg_pkg for its depth and the push/status structs.
module pwg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  pwg_pkg::point_push_type   q_push,
   input  logic                      q_pop,
   output logic [7:0]                q_idx,
   output pwg_pkg::queue_status_type q_status
);
   import pwg_pkg::*;

   logic [7:0]        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = q_push.valid ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.valid && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!q_push.valid && q_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.idx;
      end
   end

   assign q_idx          = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   // Fill stays within the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("point queue overfilled");

   // A push without a pop raises the fill by one
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      q_push.valid && !q_pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("point queue lost a push");

   // The pipeline only pops a filled queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != '0)
      else $error("point queue popped while empty");

endmodule

[hdl/pwg_back.sv]
`timescale 1ns / 1ps
// Sample pipeline: shape lookup, offset plus amplitude times shape, clip and
// scale to 16 bits, with division by the point count for the linear shapes.
// Depends on pwg_pkg for the sine table, the shape codes and the structs.
module pwg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  pwg_pkg::wave_cfg_type     cfg,
   input  pwg_pkg::queue_status_type q_status,
   input  logic [7:0]                q_idx,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_dac_sample,
   output logic [7:0]                rsp_point_index,
   output logic                      rsp_period_start
);
   import pwg_pkg::*;

   typedef struct packed {
      logic [7:0] idx;
      logic       div;
      logic       lo;
      logic       hi;
   } meta_type;

   localparam logic signed [11:0] P12      = 12'(POINTS);
   localparam logic signed [11:0] P3_12    = 12'(3 * POINTS);
   localparam logic signed [36:0] FULL_DIV = 37'(POINTS * 65536);
   localparam logic signed [36:0] FULL_PWR = 37'sh1_0000_0000;
   localparam logic [31:0]        RECIP    = 32'((64'd1 << 32) / POINTS);
   localparam logic [23:0]        P24      = 24'(POINTS);

   logic        adv;
   logic [6:0]  valid_ff;

   meta_type           m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;
   logic signed [17:0] n1_ff;
   logic signed [35:0] prod2_ff;
   logic [32:0]        offd2_ff;
   logic [31:0]        tot3_ff;
   logic [15:0]        samp4_ff, samp5_ff, samp6_ff;
   logic [23:0]        z4_ff, z5_ff, z6_ff;
   logic [55:0]        zm5_ff;
   logic [15:0]        q06_ff;
   logic [23:0]        q0p6_ff;
   logic [15:0]        dac_ff;
   logic [7:0]         idx7_ff;
   logic               start7_ff;

   logic [9:0]         two_i;
   logic               first_half;
   logic signed [11:0] four_i;
   logic signed [11:0] lin_n;
   logic signed [17:0] n1_in;
   logic               div1_in;
   logic signed [36:0] tot;
   logic               lo3_in;
   logic               hi3_in;
   logic [47:0]        scaled;
   logic [23:0]        rem;
   logic [15:0]        quot;
   logic [15:0]        dac_in;

   // Whole pipeline moves when the output register is free or being taken
   assign adv   = !valid_ff[6] || !rsp_stall;
   assign q_pop = adv && !q_status.empty;

   // Stage 1: shape value as numerator over a power of two or over POINTS
   always_comb begin
      two_i      = {1'b0, q_idx, 1'b0};
      first_half = two_i < 10'(POINTS);
      four_i     = $signed({2'b00, q_idx, 2'b00});
      lin_n      = 12'sd0;
      n1_in      = 18'sd0;
      div1_in    = 1'b0;
      unique case (cfg.shape)
         SHAPE_SINE: begin
            n1_in = SINE_TAB[q_idx[IDX_W-1:0]];
         end
         SHAPE_SQUARE: begin
            n1_in = first_half ? 18'sd65536 : -18'sd65536;
         end
         SHAPE_TRIANGLE: begin
            lin_n   = first_half ? (four_i - P12) : (P3_12 - four_i);
            n1_in   = {{6{lin_n[11]}}, lin_n};
            div1_in = 1'b1;
         end
         SHAPE_SAWTOOTH: begin
            lin_n   = $signed({3'b000, q_idx, 1'b0}) - P12;
            n1_in   = {{6{lin_n[11]}}, lin_n};
            div1_in = 1'b1;
         end
      endcase
   end

   // Stage 3: total and clip decision against full scale
   always_comb begin
      tot    = $signed({4'b0000, offd2_ff}) + $signed({prod2_ff[35], prod2_ff});
      lo3_in = tot[36] || (tot == 37'sd0);
      hi3_in = !lo3_in && (tot >= (m2_ff.div ? FULL_DIV : FULL_PWR));
   end

   // Stage 4: times 0xFFFF by shift and subtract
   assign scaled = {tot3_ff, 16'd0} - {16'd0, tot3_ff};

   // Stage 7: quotient correction and final clip
   always_comb begin
      rem  = z6_ff - q0p6_ff;
      quot = (rem >= P24) ? q06_ff + 16'd1 : q06_ff;
      if (m6_ff.lo) begin
         dac_in = 16'd0;
      end else if (m6_ff.hi) begin
         dac_in = 16'hFFFF;
      end else begin
         dac_in = m6_ff.div ? quot : samp6_ff;
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], q_pop};
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff     <= '{idx: q_idx, div: div1_in, lo: 1'b0, hi: 1'b0};
         n1_ff     <= n1_in;

         m2_ff     <= m1_ff;
         prod2_ff  <= $signed({1'b0, cfg.amplitude}) * n1_ff;
         offd2_ff  <= m1_ff.div ? 33'(cfg.offset_level) * 33'(POINTS)
                                : {cfg.offset_level, 16'd0};

         m3_ff     <= '{idx: m2_ff.idx, div: m2_ff.div, lo: lo3_in, hi: hi3_in};
         tot3_ff   <= tot[31:0];

         m4_ff     <= m3_ff;
         samp4_ff  <= scaled[47:32];
         z4_ff     <= scaled[39:16];

         m5_ff     <= m4_ff;
         samp5_ff  <= samp4_ff;
         z5_ff     <= z4_ff;
         zm5_ff    <= {32'd0, z4_ff} * {24'd0, RECIP};

         m6_ff     <= m5_ff;
         samp6_ff  <= samp5_ff;
         z6_ff     <= z5_ff;
         q06_ff    <= zm5_ff[47:32];
         q0p6_ff   <= 24'({8'd0, zm5_ff[47:32]} * P24);

         dac_ff    <= dac_in;
         idx7_ff   <= m6_ff.idx;
         start7_ff <= (m6_ff.idx == 8'd0);
      end
   end

   assign rsp_valid        = valid_ff[6];
   assign rsp_dac_sample   = dac_ff;
   assign rsp_point_index  = idx7_ff;
   assign rsp_period_start = start7_ff;

endmodule

[hdl/periodic_waveform_generator_top.sv]
`timescale 1ns / 1ps
// Periodic waveform generator for a 16-bit DAC: control registers, tick front
// end, point queue and sample pipeline. Depends on pwg_pkg and all pwg_ modules.
//
// Takes one tick/restart item every clock cycle while req_stall is low; a
// point is due on the first tick after reset or restart and then every
// point_period ticks, and each due point yields one dac_sample through the
// four-entry point queue and the seven-stage sample pipeline (shape lookup,
// multiply, add and clip, scale, and a reciprocal multiply with one
// correction step for triangle and sawtooth). Results leave at up to one
// per cycle while rsp_stall is low. While rsp_stall holds, the queue
// absorbs up to four further points before req_stall rises.
// Registers take a write on any cycle with csr_write high and should only
// change while no samples are in flight.
module periodic_waveform_generator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_tick,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_dac_sample,
   output logic [7:0]                       rsp_point_index,
   output logic                             rsp_period_start,
   input  logic                             csr_write,
   input  logic [pwg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pwg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pwg_pkg::*;

   shape_type   shape_ff;
   logic [16:0] amplitude_ff;
   logic [16:0] offset_ff;
   logic [31:0] period_ff;

   wave_cfg_type     cfg;
   point_push_type   q_push;
   queue_status_type q_status;
   logic [7:0]       q_idx;
   logic             q_pop;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff     <= SHAPE_SINE;
         amplitude_ff <= 17'd32768;
         offset_ff    <= 17'd32768;
         period_ff    <= 32'd1000;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WAVE_SHAPE:   shape_ff     <= shape_type'(csr_wdata[1:0]);
            CSR_AMPLITUDE:    amplitude_ff <= csr_wdata[16:0];
            CSR_OFFSET_LEVEL: offset_ff    <= csr_wdata[16:0];
            CSR_POINT_PERIOD: period_ff    <= csr_wdata[31:0];
         endcase
      end
   end

   assign cfg.shape        = shape_ff;
   assign cfg.amplitude    = amplitude_ff;
   assign cfg.offset_level = offset_ff;

   pwg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_tick     (req_tick),
      .req_restart  (req_restart),
      .point_period (period_ff),
      .q_status     (q_status),
      .q_push       (q_push)
   );

   pwg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_idx    (q_idx),
      .q_status (q_status)
   );

   pwg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_status         (q_status),
      .q_idx            (q_idx),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_sample   (rsp_dac_sample),
      .rsp_point_index  (rsp_point_index),
      .rsp_period_start (rsp_period_start)
   );

endmodule

[tb/periodic_waveform_generator_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for periodic_waveform_generator_top: directed and random
// tick/restart items, register settings and flow control. Depends on pwg_pkg and the RTL.
module periodic_waveform_generator_top_test;
   import pwg_pkg::*;

   localparam int SETTLE_CYCLES   = 16;    // covers the sample latency
   localparam int STUCK_LIMIT     = 2000;  // cycles with no handshake on either side
   localparam int NUM_PHASES      = 16;
   localparam int ITEMS_PER_PHASE = 62;

   typedef struct {
      logic [15:0] dac;
      logic [7:0]  idx;
      logic        start;
   } wave_point_type;

   // Tracks the generator state and holds the samples still due from the block
   class wave_scoreboard;
      localparam longint QUARTER_TURN = 64'sd1686629713;  // pi/2 in Q.30
      localparam longint UNIT         = 64'sd1073741824;  // 1.0 in Q.30

      shape_type      shape;
      logic [16:0]    amp;
      logic [16:0]    level;
      logic [31:0]    period;
      int             phase;
      logic [31:0]    count;
      wave_point_type due_q[$];
      int             errors;

      function new();
         shape  = SHAPE_SINE;
         amp    = 17'd32768;
         level  = 17'd32768;
         period = 32'd1000;
         phase  = 0;
         count  = '0;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type which, logic [31:0] v);
         case (which)
            CSR_WAVE_SHAPE:   shape  = shape_type'(v[1:0]);
            CSR_AMPLITUDE:    amp    = v[16:0];
            CSR_OFFSET_LEVEL: level  = v[16:0];
            CSR_POINT_PERIOD: period = v;
            default: ;
         endcase
      endfunction

      // sin(2*pi*i/POINTS) in Q.16: fold into a quadrant, series in Q.30
      function longint sine_point(int i);
         longint quad, rem, x, x2, term, acc, n, v;
         bit     cosine;
         quad   = ((4 * longint'(i)) / POINTS) % 4;
         rem    = (4 * longint'(i)) % POINTS;
         x      = QUARTER_TURN * rem / POINTS;
         x2     = (x * x) >>> 30;
         cosine = quad[0];
         term   = cosine ? UNIT : x;
         n      = cosine ? 0 : 1;
         acc    = term;
         for (int s = 0; s < 7; s++) begin
            term = ((term * x2) >>> 30) / ((n + 1) * (n + 2));
            n    = n + 2;
            acc  = s[0] ? acc + term : acc - term;
         end
         if (acc < 0) acc = 0;
         v = (acc + 8192) >>> 14;
         if (v > 65536) v = 65536;
         return (quad >= 2) ? -v : v;
      endfunction

      // offset plus amplitude times shape, clipped and scaled to 16 bits
      function logic [15:0] sample_at(int i);
         longint den, num, total, full;
         bit     first_half;
         first_half = (2 * i < POINTS);
         case (shape)
            SHAPE_SINE: begin
               den = 65536;
               num = sine_point(i);
            end
            SHAPE_SQUARE: begin
               den = 1;
               num = first_half ? 1 : -1;
            end
            SHAPE_TRIANGLE: begin
               den = POINTS;
               num = first_half ? 4 * i - POINTS : 3 * POINTS - 4 * i;
            end
            default: begin
               den = POINTS;
               num = 2 * i - POINTS;
            end
         endcase
         total = longint'(level) * den + longint'(amp) * num;
         full  = den * 65536;
         if (total <= 0) return 16'h0000;
         if (total >= full) return 16'hFFFF;
         return 16'((total * 65535) / full);
      endfunction

      // one accepted tick/restart item
      function void note_item(logic tick, logic restart);
         longint nxt, span;
         if (restart) begin
            phase = 0;
            count = '0;
         end
         if (!tick) return;
         if (phase >= POINTS) phase = 0;
         if (count == 0) begin
            due_q.push_back('{dac: sample_at(phase), idx: 8'(phase), start: (phase == 0)});
            phase = (phase + 1 >= POINTS) ? 0 : phase + 1;
         end
         span  = (period == 0) ? 1 : longint'(period);
         nxt   = longint'(count) + 1;
         count = (nxt >= span) ? '0 : 32'(nxt);
      endfunction

      function void complain(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      endfunction

      function void check_sample(logic [15:0] dac, logic [7:0] idx, logic start);
         wave_point_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: no sample expected, got dac_sample %0d point_index %0d",
                     $time, dac, idx);
            return;
         end
         want = due_q.pop_front();
         if (dac !== want.dac) complain("dac_sample", want.dac, dac);
         if (idx !== want.idx) complain("point_index", want.idx, idx);
         if (start !== want.start) complain("period_start", want.start, start);
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function void flag_leftovers();
         if (due_q.size() != 0) begin
            errors += due_q.size();
            $display("%0t: %0d expected samples never arrived (expected 0 left)",
                     $time, due_q.size());
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   logic                  req_tick    = 1'b0;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   logic [15:0]           rsp_dac_sample;
   logic [7:0]            rsp_point_index;
   logic                  rsp_period_start;
   logic                  csr_write   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int restart_pct   = 4;

   wave_scoreboard sb = new();

   periodic_waveform_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tick         (req_tick),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_sample   (rsp_dac_sample),
      .rsp_point_index  (rsp_point_index),
      .rsp_period_start (rsp_period_start),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_sample(rsp_dac_sample, rsp_point_index, rsp_period_start);
   end

   // Watchdog: ends the run when neither channel moves for too long
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck = 0;
         else
            stuck++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Present one item, with random sender idle cycles ahead of it
   task automatic send_item(logic tick, logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_tick    <= tick;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      sb.note_item(tick, restart);
   endtask

   // Stop sending and wait for every due sample
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Block fully idle: drained plus its pipeline depth
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(csr_index_type which, logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      sb.write_reg(which, v);
   endtask

   task automatic program_all(shape_type shp, logic [31:0] amp, logic [31:0] lvl,
                              logic [31:0] per);
      program_reg(CSR_WAVE_SHAPE, shp);
      program_reg(CSR_AMPLITUDE, amp);
      program_reg(CSR_OFFSET_LEVEL, lvl);
      program_reg(CSR_POINT_PERIOD, per);
   endtask

   function automatic logic [31:0] pick_level();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'd65536;
         2: return 32'd131071;
         3: return 32'd32768;
         4: return $urandom_range(65536);
         default: return $urandom_range(131071);
      endcase
   endfunction

   // Unused upper bits of the write data are sometimes filled with noise
   function automatic logic [31:0] add_noise(logic [31:0] v, int width);
      if ($urandom_range(3) == 0) return v | (32'($urandom) << width);
      return v;
   endfunction

   task automatic randomize_settings();
      logic [31:0] per;
      case ($urandom_range(9))
         0: per = 32'd0;
         1: per = 32'd1;
         2, 3, 4: per = $urandom_range(6, 2);
         5, 6: per = $urandom_range(40, 7);
         7: per = 32'hFFFF_FFFF;
         8: per = $urandom;
         default: per = $urandom_range(3, 1);
      endcase
      // long periods give few samples unless the phase is restarted often
      restart_pct = (per > 64) ? 30 : 4;
      program_all(shape_type'(add_noise($urandom_range(3), 2)), add_noise(pick_level(), 17),
                  add_noise(pick_level(), 17), per);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
         default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
      endcase
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: first tick emits point zero, then a long wait
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b0);
      send_item(1'b0, 1'b0);   // no time passes
      send_item(1'b0, 1'b1);   // restart alone
      send_item(1'b1, 1'b0);
      send_item(1'b1, 1'b1);   // restart and tick together

      // Zero period acts as one; square saturates high and low
      settle();
      program_all(SHAPE_SQUARE, 32'd65536, 32'd65536, 32'd0);
      repeat (11) send_item(1'b1, 1'b0);

      // Oversized amplitude with no offset
      settle();
      program_all(SHAPE_TRIANGLE, 32'd131071, 32'd0, 32'd1);
      repeat (4) send_item(1'b1, 1'b0);

      // Offset beyond full scale, then the period dropped below the tick count
      settle();
      program_all(SHAPE_SAWTOOTH, 32'd0, 32'd131071, 32'd1000);
      repeat (3) send_item(1'b1, 1'b0);
      settle();
      program_reg(CSR_POINT_PERIOD, 32'd2);
      repeat (3) send_item(1'b1, 1'b0);

      // Random phases over settings and idling patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         randomize_settings();
         set_idling(p % 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2 && p % 3 == 0)
               drain();
            send_item($urandom_range(99) < 85, $urandom_range(99) < restart_pct);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/pwg_pkg.sv
hdl/pwg_front.sv
hdl/pwg_queue.sv
hdl/pwg_back.sv
hdl/periodic_waveform_generator_top.sv
tb/periodic_waveform_generator_top_test.sv
